/* rtl/core/ed3b_pkg.sv */
// Package for the 3x3 edge detector with binarization.
// Holds register indexes, widths, reset values, edge levels and the first-stage word type.
// Used by edge_detect_3x3_binarize and its testbench; depends on nothing.
package ed3b_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROI_START_X  = 3'd2;
    localparam logic [2:0] REG_ROI_START_Y  = 3'd3;
    localparam logic [2:0] REG_ROI_END_X    = 3'd4;
    localparam logic [2:0] REG_ROI_END_Y    = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_W     = 11;
    localparam int START_W    = 10;
    localparam int POS_W      = 10;
    localparam int PIXEL_W    = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [SIZE_W-1:0]  RST_IMAGE_SIZE = 11'd256;
    localparam logic [START_W-1:0] RST_ROI_START  = 10'd0;
    localparam logic [SIZE_W-1:0]  RST_ROI_END    = 11'd256;

    localparam int MIN_SIZE = 3;

    localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

    // One pixel word held between the input register and the result register.
    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic [POS_W-1:0]   cx;
        logic [POS_W-1:0]   cy;
        logic               emit;
    } t_s1_word;

endpackage

/* rtl/core/ed3b_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the two line stores of the edge detector; no dependencies.
module ed3b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/edge_detect_3x3_binarize.sv */
// Top level of the streaming 3x3 edge detector with binarization.
// Depends on ed3b_pkg and ed3b_ram (two line stores).
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata: pixel[7:0]; tuser: frame_start[0]
//  m_axis   | out       | tdata: centre_col[9:0], centre_row[19:10],
//           |           |        edge_value[27:20], zero pad[31:28]
//  cfg      | in        | i_cfg_wen, i_cfg_idx, i_cfg_wdata (write only)
//
// One pixel word is accepted per cycle while input ready is high; a result passes the
// first-stage register, which matches the registered line store read, then the output register.
// Reset is synchronous; it clears counters, window and valid flags and loads the configuration reset values.
// A stalled output holds the result; the first stage still drains words that
// give no result, and input ready falls only when both stages are blocked.
module edge_detect_3x3_binarize
    import ed3b_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Pixel input.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // pixel[7:0]
    input  logic [0:0]            s_axis_tuser,   // frame_start[0]
    // Result output.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // centre_col, centre_row, edge_value
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CRW = (CW > RW) ? CW : RW;
    localparam int PW  = (CRW + 1 > SIZE_W) ? CRW + 1 : SIZE_W;
    localparam logic [PW-1:0] MAX_W_P = PW'(MAX_WIDTH);
    localparam logic [PW-1:0] MAX_H_P = PW'(MAX_HEIGHT);
    localparam logic [PW-1:0] MIN_P   = PW'(MIN_SIZE);
    localparam logic [PW-1:0] ONE_P   = PW'(1);
    localparam logic [PW-1:0] TWO_P   = PW'(2);
    localparam int PAD_W = OUT_DATA_W - 2 * POS_W - PIXEL_W;

    // Configuration registers.
    logic [SIZE_W-1:0]  r_img_w, r_img_h, r_roi_ex, r_roi_ey;
    logic [START_W-1:0] r_roi_sx, r_roi_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= RST_IMAGE_SIZE;
            r_img_h  <= RST_IMAGE_SIZE;
            r_roi_sx <= RST_ROI_START;
            r_roi_sy <= RST_ROI_START;
            r_roi_ex <= RST_ROI_END;
            r_roi_ey <= RST_ROI_END;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT: r_img_h  <= i_cfg_wdata;
                REG_ROI_START_X:  r_roi_sx <= i_cfg_wdata[START_W-1:0];
                REG_ROI_START_Y:  r_roi_sy <= i_cfg_wdata[START_W-1:0];
                REG_ROI_END_X:    r_roi_ex <= i_cfg_wdata;
                REG_ROI_END_Y:    r_roi_ey <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective image size and region bounds.
    logic [PW-1:0] img_w_x, img_h_x, w_eff, h_eff;
    logic [PW-1:0] sx_x, sy_x, ex_x, ey_x, sx_eff, sy_eff, ex_eff, ey_eff;

    always_comb begin
        img_w_x = PW'(r_img_w);
        img_h_x = PW'(r_img_h);
        if (img_w_x < MIN_P) begin
            w_eff = MIN_P;
        end else if (img_w_x > MAX_W_P) begin
            w_eff = MAX_W_P;
        end else begin
            w_eff = img_w_x;
        end
        if (img_h_x < MIN_P) begin
            h_eff = MIN_P;
        end else if (img_h_x > MAX_H_P) begin
            h_eff = MAX_H_P;
        end else begin
            h_eff = img_h_x;
        end
        sx_x   = PW'(r_roi_sx);
        sy_x   = PW'(r_roi_sy);
        ex_x   = PW'(r_roi_ex);
        ey_x   = PW'(r_roi_ey);
        sx_eff = (sx_x == '0) ? ONE_P : sx_x;
        sy_eff = (sy_x == '0) ? ONE_P : sy_x;
        // An end at or past the image size is the last column or row.
        ex_eff = (ex_x >= w_eff) ? w_eff - ONE_P : ex_x;
        ey_eff = (ey_x >= h_eff) ? h_eff - ONE_P : ey_x;
    end

    // Handshake and stage control.
    logic     r_s1_valid;
    t_s1_word r_s1;
    logic     r_out_valid;
    logic     out_free, s1_adv, in_acc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && (!r_s1.emit || out_free);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Position of the accepted pixel and the verdict on its window centre.
    logic [CW-1:0] r_col, col_eff, n_col;
    logic [RW-1:0] r_row, row_eff, n_row;
    logic [PW-1:0] col_x, row_x, cx_x, cy_x;
    logic          emit;

    always_comb begin
        col_eff = s_axis_tuser[0] ? '0 : r_col;
        row_eff = s_axis_tuser[0] ? '0 : r_row;
        col_x   = PW'(col_eff);
        row_x   = PW'(row_eff);
        cx_x    = col_x - ONE_P;
        cy_x    = row_x - ONE_P;
        emit    = (col_x >= TWO_P) && (row_x >= TWO_P) && (col_x < w_eff) && (row_x < h_eff)
                  && (cx_x >= sx_eff) && (cx_x < ex_eff)
                  && (cy_x >= sy_eff) && (cy_x < ey_eff);
        if (col_x + ONE_P >= w_eff) begin
            n_col = '0;
            n_row = (row_x + ONE_P >= h_eff) ? '0 : row_eff + RW'(1);
        end else begin
            n_col = col_eff + CW'(1);
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores: store a holds the previous line, store b the one before it.
    logic [CW-1:0]      r_s1_addr;
    logic [PIXEL_W-1:0] rd_a, rd_b, top_s1, mid_s1;
    logic               r_s1_byp;
    logic [PIXEL_W-1:0] r_byp_top, r_byp_mid;

    ed3b_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1.px),
        .i_re    (in_acc),
        .i_raddr (col_eff),
        .o_rdata (rd_a)
    );

    ed3b_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_s1),
        .i_re    (in_acc),
        .i_raddr (col_eff),
        .o_rdata (rd_b)
    );

    // A read of the column being written in the same cycle takes the new data.
    assign top_s1 = r_s1_byp ? r_byp_top : rd_b;
    assign mid_s1 = r_s1_byp ? r_byp_mid : rd_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_byp   <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_s1_byp   <= s1_adv && (col_eff == r_s1_addr);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_byp   <= 1'b0;
        end
        if (in_acc) begin
            r_s1.px   <= s_axis_tdata;
            r_s1.cx   <= cx_x[POS_W-1:0];
            r_s1.cy   <= cy_x[POS_W-1:0];
            r_s1.emit <= emit;
            r_s1_addr <= col_eff;
            r_byp_top <= mid_s1;
            r_byp_mid <= r_s1.px;
        end
    end

    // Window: columns two back (0..2) and one back (3..5), top to bottom.
    logic [PIXEL_W-1:0] r_win [6];
    logic [PIXEL_W-1:0] nb_sum;
    logic [PIXEL_W-1:0] edge_val;

    always_comb begin
        nb_sum = PIXEL_W'(r_win[0] >> 3) + PIXEL_W'(r_win[1] >> 3)
               + PIXEL_W'(r_win[2] >> 3) + PIXEL_W'(r_win[3] >> 3)
               + PIXEL_W'(r_win[5] >> 3) + PIXEL_W'(top_s1 >> 3)
               + PIXEL_W'(mid_s1 >> 3)   + PIXEL_W'(r_s1.px >> 3);
        edge_val = (nb_sum > r_win[4]) ? EDGE_ON : EDGE_OFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_s1;
            r_win[4] <= mid_s1;
            r_win[5] <= r_s1.px;
        end
    end

    // Result register.
    logic [POS_W-1:0]   r_out_cx, r_out_cy;
    logic [PIXEL_W-1:0] r_out_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv && r_s1.emit) begin
            r_out_cx   <= r_s1.cx;
            r_out_cy   <= r_s1.cy;
            r_out_edge <= edge_val;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_edge, r_out_cy, r_out_cx};

`ifndef NO_ASSERTIONS
    // The same-cycle forwarding path is only armed behind a live word.
    a_byp_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_byp |-> r_s1_valid)
        else $error("forwarding flag set without a word in the first stage");

    // A word taken while the first stage is full must push the old word on.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_valid) |-> s1_adv)
        else $error("first-stage word overwritten");

    // Results are binary.
    a_edge_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_edge == EDGE_ON || r_out_edge == EDGE_OFF))
        else $error("edge value is neither on nor off");

    // Centres in the first column or row never produce a result.
    a_no_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cx != '0 && r_out_cy != '0))
        else $error("result for a border centre");

    // Column counter stays inside the line store.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (PW'(r_col) < w_eff || $past(w_eff) != w_eff))
        else $error("column counter past the line end");
`endif

endmodule

/* verif/edge_detect_3x3_binarize_tb.sv */
// Self-checking testbench for the streaming 3x3 edge detector with binarization.
// Runs a directed table, then mid-frame size shrinks, extreme sizes and random phases.
// Depends on ed3b_pkg and the edge_detect_3x3_binarize RTL.
module edge_detect_3x3_binarize_tb;
    import ed3b_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int COL_W         = $clog2(MAX_W);
    localparam int RANDOM_ITEMS  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 8;
    localparam int RUN_LIMIT_NS  = 5000000;

    typedef struct packed {
        logic [POS_W-1:0]   centre_col;
        logic [POS_W-1:0]   centre_row;
        logic [PIXEL_W-1:0] edge_value;
    } t_edge_result;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [PIXEL_W-1:0]    px;
        logic                  fs;
        logic                  typed;
        t_edge_result          want;
    } t_stim_row;

    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} t_pix_mode;

    // Two 3x3 frames on the smallest image: a dark centre ringed by white pixels, then a
    // flat frame where the neighbour eighths exactly cancel the centre. The second frame
    // follows by line and frame wrap, and two restarts by frame_start close the table.
    localparam t_stim_row DIRECTED [23] = '{
        '{1'b1, REG_IMAGE_WIDTH,  11'd0, 8'd0,   1'b0, 1'b0, '0},
        '{1'b1, REG_IMAGE_HEIGHT, 11'd2, 8'd0,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b1, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd0,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b1, '{10'd1, 10'd1, EDGE_ON}},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd8,   1'b0, 1'b1, '{10'd1, 10'd1, EDGE_OFF}},
        '{1'b0, '0, '0, 8'd0,   1'b1, 1'b0, '0},
        '{1'b0, '0, '0, 8'd255, 1'b0, 1'b0, '0},
        '{1'b0, '0, '0, 8'd128, 1'b1, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // pixel[7:0]
    logic [0:0]            s_axis_tuser;   // frame_start[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // centre_col[9:0], centre_row[19:10], edge_value[27:20]

    edge_detect_3x3_binarize u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Edge predictor state, mirroring the block from reset on.
    logic [SIZE_W-1:0]  pred_width    = RST_IMAGE_SIZE;
    logic [SIZE_W-1:0]  pred_height   = RST_IMAGE_SIZE;
    logic [START_W-1:0] pred_start_x  = RST_ROI_START;
    logic [START_W-1:0] pred_start_y  = RST_ROI_START;
    logic [SIZE_W-1:0]  pred_end_x    = RST_ROI_END;
    logic [SIZE_W-1:0]  pred_end_y    = RST_ROI_END;
    logic [7:0]         prev_line  [MAX_W] = '{default: 8'd0};
    logic [7:0]         older_line [MAX_W] = '{default: 8'd0};
    logic [7:0]         window     [6]     = '{default: 8'd0};
    int unsigned        pred_col = 0;
    int unsigned        pred_row = 0;

    t_edge_result expected_q [$];
    int           err_count    = 0;
    int           random_items = 0;
    bit           sender_gaps  = 1'b1;
    bit           hold_output  = 1'b0;

    function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] v, input int unsigned maxv);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_end(input logic [SIZE_W-1:0] e, input int unsigned size);
        if (e >= size) return size - 1;
        return 32'(e);
    endfunction

    // Consumes one pixel word; returns 1 and the result when a centre is judged.
    function automatic bit edge_step(input logic [7:0] px, input logic fs,
                                     output t_edge_result res);
        int unsigned w, h, cx, cy, sx, sy, ex, ey;
        logic [7:0]  top, mid;
        int          sum;
        bit          hit;
        w   = eff_dim(pred_width, MAX_W);
        h   = eff_dim(pred_height, MAX_H);
        top = 8'd0;
        mid = 8'd0;
        hit = 1'b0;
        res = '0;
        if (fs) begin
            pred_col = 0;
            pred_row = 0;
        end
        if (pred_col < MAX_W) begin
            top = older_line[pred_col[COL_W-1:0]];
            mid = prev_line[pred_col[COL_W-1:0]];
            older_line[pred_col[COL_W-1:0]] = mid;
            prev_line[pred_col[COL_W-1:0]]  = px;
        end
        if (pred_col >= 2 && pred_row >= 2 && pred_col < w && pred_row < h) begin
            cx = pred_col - 1;
            cy = pred_row - 1;
            sx = (pred_start_x == '0) ? 1 : 32'(pred_start_x);
            sy = (pred_start_y == '0) ? 1 : 32'(pred_start_y);
            ex = eff_end((32'(pred_end_x) == w) ? SIZE_W'(w - 1) : pred_end_x, w);
            ey = eff_end((32'(pred_end_y) == h) ? SIZE_W'(h - 1) : pred_end_y, h);
            if (cx >= sx && cx < ex && cy >= sy && cy < ey) begin
                sum = int'(window[0] >> 3) + int'(window[1] >> 3) + int'(window[2] >> 3)
                    + int'(window[3] >> 3) + int'(window[5] >> 3) + int'(top >> 3)
                    + int'(mid >> 3) + int'(px >> 3) - int'(window[4]);
                res.centre_col = cx[POS_W-1:0];
                res.centre_row = cy[POS_W-1:0];
                res.edge_value = (sum > 0) ? EDGE_ON : EDGE_OFF;
                hit = 1'b1;
            end
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = px;
        if (pred_col + 1 >= w) begin
            pred_col = 0;
            if (pred_row + 1 >= h) pred_row = 0;
            else pred_row++;
        end else begin
            pred_col++;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        if (!sender_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_pixel(input t_pix_mode mode);
        case (mode)
            PIX_UNIFORM: return 8'($urandom_range(0, 255));
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:     return 8'($urandom_range(6, 17));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_dim(input int unsigned maxv);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return SIZE_W'($urandom_range(0, MIN_SIZE - 1));
        if (r < 90) return SIZE_W'($urandom_range(MIN_SIZE, maxv));
        return SIZE_W'($urandom_range(maxv + 1, 2 * maxv));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_start(input int unsigned size);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return '0;
        if (r < 90) return CFG_DATA_W'($urandom_range(0, size));
        return CFG_DATA_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_end(input int unsigned size);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CFG_DATA_W'(size);
        if (r < 85) return CFG_DATA_W'($urandom_range(0, size + 1));
        return CFG_DATA_W'($urandom_range(1024, 2047));
    endfunction

    task automatic send_pixel(input logic [7:0] px, input logic fs, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic feed(input logic [7:0] px, input logic fs);
        t_edge_result res;
        send_pixel(px, fs, pick_gap());
        if (edge_step(px, fs, res)) expected_q.push_back(res);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:  pred_width   = val;
            REG_IMAGE_HEIGHT: pred_height  = val;
            REG_ROI_START_X:  pred_start_x = val[START_W-1:0];
            REG_ROI_START_Y:  pred_start_y = val[START_W-1:0];
            REG_ROI_END_X:    pred_end_x   = val;
            REG_ROI_END_Y:    pred_end_y   = val;
            default: ;
        endcase
    endtask

    // Stops sending, waits for every expected word, then lets words that give no
    // result clear the pipeline.
    task automatic settle();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_q.size() != 0) begin
            report_mismatch("results never arrived", expected_q.size(), 0);
            expected_q.delete();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // A width that grows mid-frame would read line store entries never written, so a
    // wider image always restarts the frame.
    task automatic random_phase(input int phase_no);
        int unsigned old_w, w, h, npix;
        t_pix_mode   pmode;
        bit          full, fs;
        old_w = eff_dim(pred_width, MAX_W);
        full  = (phase_no == 0);
        settle();
        if (full) begin
            cfg_write(REG_IMAGE_WIDTH, 11'd12);
            cfg_write(REG_IMAGE_HEIGHT, 11'd8);
        end else begin
            if ($urandom_range(0, 3) != 0) cfg_write(REG_IMAGE_WIDTH, pick_dim(16));
            if ($urandom_range(0, 3) != 0) cfg_write(REG_IMAGE_HEIGHT, pick_dim(12));
        end
        w = eff_dim(pred_width, MAX_W);
        h = eff_dim(pred_height, MAX_H);
        if (full || $urandom_range(0, 2) != 0)
            cfg_write(REG_ROI_START_X, full ? '0 : pick_start(w));
        if (full || $urandom_range(0, 2) != 0)
            cfg_write(REG_ROI_START_Y, full ? '0 : pick_start(h));
        if (full || $urandom_range(0, 2) != 0)
            cfg_write(REG_ROI_END_X, full ? CFG_DATA_W'(w) : pick_end(w));
        if (full || $urandom_range(0, 2) != 0)
            cfg_write(REG_ROI_END_Y, full ? CFG_DATA_W'(h) : pick_end(h));
        pmode       = t_pix_mode'($urandom_range(0, 2));
        sender_gaps = !full && ($urandom_range(0, 3) != 0);
        // In the full first phase the output is held off for a long stretch while pixels keep coming.
        if (full) hold_output = 1'b1;
        npix = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h);
        for (int unsigned i = 0; i < npix; i++) begin
            if (i == 0) fs = (w > old_w) || ($urandom_range(0, 3) != 0);
            else fs = ($urandom_range(0, 149) == 0);
            feed(pick_pixel(pmode), fs);
        end
        random_items += int'(npix);
    endtask

    // Output side: random stalls in changing modes, plus one long hold on request.
    initial begin : result_sink
        int stall_left;
        int mode_left;
        int mode;
        stall_left = 0;
        mode_left  = 0;
        mode       = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                repeat (HOLD_CYCLES) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_output = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else if (mode != 0 && $urandom_range(0, 99) < ((mode == 1) ? 15 : 40)) begin
                    stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                               : $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_edge_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result word with none expected", m_axis_tdata, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[9:0] !== want.centre_col)
                    report_mismatch("centre_col", 32'(m_axis_tdata[9:0]),
                                    32'(want.centre_col));
                if (m_axis_tdata[19:10] !== want.centre_row)
                    report_mismatch("centre_row", 32'(m_axis_tdata[19:10]),
                                    32'(want.centre_row));
                if (m_axis_tdata[27:20] !== want.edge_value)
                    report_mismatch("edge_value", 32'(m_axis_tdata[27:20]),
                                    32'(want.edge_value));
                if (m_axis_tdata[31:28] !== 4'd0)
                    report_mismatch("tdata pad", 32'(m_axis_tdata[31:28]), 0);
            end
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_edge_result res;
        bit           hit;
        int           phase_no;
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].is_cfg) begin
                settle();
                cfg_write(DIRECTED[k].idx, DIRECTED[k].value);
            end else begin
                send_pixel(DIRECTED[k].px, DIRECTED[k].fs, pick_gap());
                hit = edge_step(DIRECTED[k].px, DIRECTED[k].fs, res);
                if (DIRECTED[k].typed) expected_q.push_back(DIRECTED[k].want);
                else if (hit) expected_q.push_back(res);
            end
        end

        // Sizes shrink mid-frame so that the column, then the row, lies past the end.
        settle();
        cfg_write(REG_IMAGE_WIDTH, 11'd12);
        cfg_write(REG_IMAGE_HEIGHT, 11'd10);
        cfg_write(REG_ROI_START_X, 11'd0);
        cfg_write(REG_ROI_START_Y, 11'd0);
        cfg_write(REG_ROI_END_X, 11'd12);
        cfg_write(REG_ROI_END_Y, 11'd10);
        for (int i = 0; i < 12 * 5 + 8; i++) feed(pick_pixel(PIX_UNIFORM), i == 0);
        settle();
        cfg_write(REG_IMAGE_WIDTH, 11'd6);
        for (int i = 0; i < 6 * 3 + 2; i++) feed(pick_pixel(PIX_UNIFORM), 1'b0);
        settle();
        cfg_write(REG_IMAGE_HEIGHT, 11'd4);
        for (int i = 0; i < 6 * 4 * 2 + 3; i++) feed(pick_pixel(PIX_UNIFORM), 1'b0);

        // Widest image, clamped from the largest register value: the first line wraps
        // after the widest line, then the width drops to three so that one window closes
        // on the first columns of the second and third lines.
        settle();
        cfg_write(REG_IMAGE_WIDTH, 11'd2047);
        cfg_write(REG_IMAGE_HEIGHT, 11'd3);
        cfg_write(REG_ROI_END_X, 11'd1024);
        cfg_write(REG_ROI_END_Y, 11'd3);
        for (int i = 0; i < MAX_W + 3; i++) feed(pick_pixel(PIX_UNIFORM), i == 0);
        settle();
        cfg_write(REG_IMAGE_WIDTH, 11'd3);
        for (int i = 0; i < 4; i++) feed(pick_pixel(PIX_UNIFORM), 1'b0);

        // Tallest image, only the first lines of it.
        settle();
        cfg_write(REG_IMAGE_WIDTH, 11'd3);
        cfg_write(REG_IMAGE_HEIGHT, 11'd1024);
        cfg_write(REG_ROI_END_Y, 11'd2047);
        for (int i = 0; i < 3 * 40; i++) feed(pick_pixel(PIX_UNIFORM), i == 0);

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            random_phase(phase_no);
            phase_no++;
        end

        settle();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* edge_detect_3x3_binarize.f */
rtl/core/ed3b_pkg.sv
rtl/core/ed3b_ram.sv
rtl/core/edge_detect_3x3_binarize.sv
verif/edge_detect_3x3_binarize_tb.sv
